[rtl/wllh_pkg.sv]
// ----------------------------------------------------------------------------
// wllh_pkg
// Shared constants, types and helpers of the wakeup latency log2 histogram.
// ----------------------------------------------------------------------------
package wllh_pkg;

    // Table and histogram sizing (TABLE_DEPTH is a power of two)
    localparam int TABLE_DEPTH = 4096;
    localparam int NUM_BUCKETS = 64;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    localparam int BKT_AW      = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;

    // Clearing sweep covers both memories
    localparam int CLR_LEN = (TABLE_DEPTH > NUM_BUCKETS) ? TABLE_DEPTH : NUM_BUCKETS;
    localparam int CLR_W   = $clog2(CLR_LEN);

    // Field widths
    localparam int MODE_W   = 2;
    localparam int TID_W    = 12;
    localparam int TS_W     = 64;
    localparam int RB_W     = 6;
    localparam int BUCKET_W = 6;
    localparam int COUNT_W  = 64;

    // Stream packing
    localparam int IN_DATA_W  = ((TID_W + TS_W + RB_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((BUCKET_W + COUNT_W + 7) / 8) * 8;
    localparam int TS_LSB     = TID_W;
    localparam int RB_LSB     = TID_W + TS_W;
    localparam int CNT_LSB    = BUCKET_W;

    // Table entry: valid mark over the start timestamp
    localparam int ENTRY_W = TS_W + 1;

    // Event codes
    localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FINISH = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_BUCKET,
        ST_COUNT,
        ST_RDATA,
        ST_RESP
    } state_t;

    // floor(log2(d)), 0 for d of 0 or 1, clamped to the last bucket
    function automatic logic [BKT_AW-1:0] log2_bucket(input logic [TS_W-1:0] d);
        logic [BUCKET_W-1:0] b;
        b = '0;
        for (int i = 1; i < TS_W; i++) begin
            if (d[i]) begin
                b = BUCKET_W'(i);
            end
        end
        if (b > BUCKET_W'(NUM_BUCKETS - 1)) begin
            b = BUCKET_W'(NUM_BUCKETS - 1);
        end
        return BKT_AW'(b);
    endfunction

endpackage

[rtl/wllh_ram.sv]
// ----------------------------------------------------------------------------
// wllh_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wllh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/wakeup_latency_log2_histogram.sv]
// ----------------------------------------------------------------------------
// wakeup_latency_log2_histogram
// Per-thread wait latency measurement with a log2 histogram of the latencies.
// ----------------------------------------------------------------------------
// One item is in work at a time. A start event or an unused mode goes from
// acceptance straight to the response state, a read passes through the read
// data state, an unmatched finish through the table lookup, and a matched
// finish through table read, subtract, log2 and counter read, and counter
// write-back. The result sits in an output register, so the next item is
// taken while it waits for the downstream side. After reset the block sweeps
// both memories, one entry per cycle, with s_axis_tready low.
module wakeup_latency_log2_histogram (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: thread_id, timestamp_ns, read_bucket, zero fill
    input  logic [wllh_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // tuser: mode
    input  logic [wllh_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tdata: bucket, count, zero fill
    output logic [wllh_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // tuser: matched
    output logic                              m_axis_tuser
);

    wllh_pkg::state_t state_reg, state_next;

    logic [wllh_pkg::CLR_W-1:0]    clr_reg, clr_next;
    logic [wllh_pkg::TBL_AW-1:0]   idx_reg, idx_next;
    logic [wllh_pkg::TS_W-1:0]     ts_reg, ts_next;
    logic [wllh_pkg::RB_W-1:0]     rb_reg, rb_next;
    logic [wllh_pkg::TS_W-1:0]     delta_reg, delta_next;
    logic [wllh_pkg::BKT_AW-1:0]   bkt_reg, bkt_next;
    logic                          res_matched_reg, res_matched_next;
    logic [wllh_pkg::BUCKET_W-1:0] res_bucket_reg, res_bucket_next;
    logic [wllh_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_matched_reg, out_matched_next;
    logic [wllh_pkg::BUCKET_W-1:0] out_bucket_reg, out_bucket_next;
    logic [wllh_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;

    // Memory ports
    logic                           tbl_we, tbl_re;
    logic [wllh_pkg::TBL_AW-1:0]    tbl_waddr, tbl_raddr;
    logic [wllh_pkg::ENTRY_W-1:0]   tbl_wdata, tbl_rdata;
    logic                           cnt_we, cnt_re;
    logic [wllh_pkg::BKT_AW-1:0]    cnt_waddr, cnt_raddr;
    logic [wllh_pkg::COUNT_W-1:0]   cnt_wdata, cnt_rdata;

    // Input field unpacking
    logic [wllh_pkg::MODE_W-1:0]   in_mode;
    logic [wllh_pkg::TID_W-1:0]    in_tid;
    logic [wllh_pkg::TS_W-1:0]     in_ts;
    logic [wllh_pkg::RB_W-1:0]     in_rb;
    logic                          in_accept;
    logic                          out_free;
    logic [wllh_pkg::BKT_AW-1:0]   delta_bkt;
    logic [wllh_pkg::COUNT_W-1:0]  cnt_inc;

    assign in_mode = s_axis_tuser;
    assign in_tid  = s_axis_tdata[wllh_pkg::TID_W-1:0];
    assign in_ts   = s_axis_tdata[wllh_pkg::TS_LSB +: wllh_pkg::TS_W];
    assign in_rb   = s_axis_tdata[wllh_pkg::RB_LSB +: wllh_pkg::RB_W];

    assign s_axis_tready = (state_reg == wllh_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign delta_bkt     = wllh_pkg::log2_bucket(delta_reg);
    assign cnt_inc       = cnt_rdata + wllh_pkg::COUNT_W'(1);

    // Start-time table: {valid, timestamp}
    wllh_ram #(
        .WIDTH (wllh_pkg::ENTRY_W),
        .DEPTH (wllh_pkg::TABLE_DEPTH)
    ) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    // Histogram counters
    wllh_ram #(
        .WIDTH (wllh_pkg::COUNT_W),
        .DEPTH (wllh_pkg::NUM_BUCKETS)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (cnt_re),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wllh_pkg::ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        ts_reg          <= ts_next;
        rb_reg          <= rb_next;
        delta_reg       <= delta_next;
        bkt_reg         <= bkt_next;
        res_matched_reg <= res_matched_next;
        res_bucket_reg  <= res_bucket_next;
        res_count_reg   <= res_count_next;
        out_matched_reg <= out_matched_next;
        out_bucket_reg  <= out_bucket_next;
        out_count_reg   <= out_count_next;
    end

    // Sequencer: next state, memory accesses, result
    always_comb
    begin
        state_next       = state_reg;
        clr_next         = clr_reg;
        idx_next         = idx_reg;
        ts_next          = ts_reg;
        rb_next          = rb_reg;
        delta_next       = delta_reg;
        bkt_next         = bkt_reg;
        res_matched_next = res_matched_reg;
        res_bucket_next  = res_bucket_reg;
        res_count_next   = res_count_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_matched_next = out_matched_reg;
        out_bucket_next  = out_bucket_reg;
        out_count_next   = out_count_reg;

        tbl_we    = 1'b0;
        tbl_waddr = idx_reg;
        tbl_wdata = '0;
        tbl_re    = 1'b0;
        tbl_raddr = wllh_pkg::TBL_AW'(in_tid);
        cnt_we    = 1'b0;
        cnt_waddr = bkt_reg;
        cnt_wdata = '0;
        cnt_re    = 1'b0;
        cnt_raddr = wllh_pkg::BKT_AW'(in_rb);

        case (state_reg)
            // Sweep both memories to zero after reset
            wllh_pkg::ST_CLEAR:
            begin
                tbl_we    = (int'(clr_reg) < wllh_pkg::TABLE_DEPTH);
                tbl_waddr = wllh_pkg::TBL_AW'(clr_reg);
                cnt_we    = (int'(clr_reg) < wllh_pkg::NUM_BUCKETS);
                cnt_waddr = wllh_pkg::BKT_AW'(clr_reg);
                clr_next  = clr_reg + wllh_pkg::CLR_W'(1);
                if (int'(clr_reg) == wllh_pkg::CLR_LEN - 1)
                begin
                    state_next = wllh_pkg::ST_IDLE;
                end
            end

            wllh_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    idx_next         = wllh_pkg::TBL_AW'(in_tid);
                    ts_next          = in_ts;
                    rb_next          = in_rb;
                    res_matched_next = 1'b0;
                    res_bucket_next  = '0;
                    res_count_next   = '0;
                    state_next       = wllh_pkg::ST_RESP;
                    case (in_mode)
                        wllh_pkg::MODE_START:
                        begin
                            tbl_we    = 1'b1;
                            tbl_waddr = wllh_pkg::TBL_AW'(in_tid);
                            tbl_wdata = {1'b1, in_ts};
                        end
                        wllh_pkg::MODE_FINISH:
                        begin
                            tbl_re     = 1'b1;
                            state_next = wllh_pkg::ST_LOOKUP;
                        end
                        wllh_pkg::MODE_READ:
                        begin
                            cnt_re     = 1'b1;
                            state_next = wllh_pkg::ST_RDATA;
                        end
                        default:
                        begin
                            state_next = wllh_pkg::ST_RESP;
                        end
                    endcase
                end
            end

            // Table entry arrived: subtract and retire the entry on a hit
            wllh_pkg::ST_LOOKUP:
            begin
                if (tbl_rdata[wllh_pkg::TS_W])
                begin
                    delta_next = ts_reg - tbl_rdata[wllh_pkg::TS_W-1:0];
                    tbl_we     = 1'b1;
                    tbl_waddr  = idx_reg;
                    tbl_wdata  = '0;
                    state_next = wllh_pkg::ST_BUCKET;
                end
                else
                begin
                    state_next = wllh_pkg::ST_RESP;
                end
            end

            // Log2 of the latency, fetch that counter
            wllh_pkg::ST_BUCKET:
            begin
                bkt_next   = delta_bkt;
                cnt_re     = 1'b1;
                cnt_raddr  = delta_bkt;
                state_next = wllh_pkg::ST_COUNT;
            end

            // Increment and write back the counter
            wllh_pkg::ST_COUNT:
            begin
                cnt_we           = 1'b1;
                cnt_waddr        = bkt_reg;
                cnt_wdata        = cnt_inc;
                res_matched_next = 1'b1;
                res_bucket_next  = wllh_pkg::BUCKET_W'(bkt_reg);
                res_count_next   = cnt_inc;
                state_next       = wllh_pkg::ST_RESP;
            end

            // Histogram read data arrived
            wllh_pkg::ST_RDATA:
            begin
                res_bucket_next = rb_reg;
                if (int'(rb_reg) < wllh_pkg::NUM_BUCKETS)
                begin
                    res_count_next = cnt_rdata;
                end
                state_next = wllh_pkg::ST_RESP;
            end

            // Hand the result to the output register once it is free
            wllh_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_matched_next = res_matched_reg;
                    out_bucket_next  = res_bucket_reg;
                    out_count_next   = res_count_reg;
                    state_next       = wllh_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = wllh_pkg::ST_IDLE;
            end
        endcase
    end

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_matched_reg;
    assign m_axis_tdata  = {
        (wllh_pkg::OUT_DATA_W - wllh_pkg::BUCKET_W - wllh_pkg::COUNT_W)'(0),
        out_count_reg,
        out_bucket_reg
    };

endmodule

[rtl/wllh_checker.sv]
// ----------------------------------------------------------------------------
// wllh_assert
// Port-level checks of the wakeup latency log2 histogram, bound to the top.
// ----------------------------------------------------------------------------
module wllh_assert (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [wllh_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [wllh_pkg::MODE_W-1:0]     s_axis_tuser,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [wllh_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input logic                            m_axis_tuser
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg, pend_next;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // Items taken but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!in_acc && out_acc)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // A waiting input item holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=>
            s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
        else $error("input item changed while waiting");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // One item in work at a time: no item right after another
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("item taken in the cycle after another");

    // No result without an item behind it
    a_no_extra_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc |-> pend_reg != 2'd0)
        else $error("result without an item");

    // Ready only while at most one result is owed
    a_ready_bound: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> pend_reg <= 2'd1)
        else $error("ready with two results owed");

endmodule

bind wakeup_latency_log2_histogram wllh_assert u_wllh_assert (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

[tb/wllh_checker.sv]
// ----------------------------------------------------------------------------
// wllh_checker
// Watches both stream ports of the wakeup latency histogram. It keeps its own
// start-time table and bucket counters, works out the response of every
// accepted event, and compares each returned item field by field, in order.
// ----------------------------------------------------------------------------
module wllh_checker
    import wllh_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [MODE_W-1:0]       s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                    m_axis_tuser,
    output int                      fail_count,
    output int                      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                matched;
        logic [BUCKET_W-1:0] bucket;
        logic [COUNT_W-1:0]  count;
    } hist_resp_t;

    // Shadow of the block state
    logic [TS_W-1:0]    start_stamp [TABLE_DEPTH];
    logic               start_armed [TABLE_DEPTH];
    logic [COUNT_W-1:0] bucket_hits [NUM_BUCKETS];

    // Responses owed by the block, oldest first
    hist_resp_t responses_due [$];
    hist_resp_t oldest;

    initial fail_count = 0;

    // floor(log2(d)), 0 for d of 0 or 1, limited to the last bucket
    function automatic int latency_bucket(input logic [TS_W-1:0] d);
        int b;
        b = 0;
        for (int i = TS_W - 1; i >= 1; i--) begin
            if (d[i] && b == 0) begin
                b = i;
            end
        end
        if (b > NUM_BUCKETS - 1) begin
            b = NUM_BUCKETS - 1;
        end
        return b;
    endfunction

    // Apply one event to the shadow state and return the response it owes
    function automatic hist_resp_t advance_histogram(input logic [MODE_W-1:0] mode,
                                                     input logic [TID_W-1:0]  tid,
                                                     input logic [TS_W-1:0]   ts,
                                                     input logic [RB_W-1:0]   rb);
        hist_resp_t r;
        int         idx;
        int         b;
        r   = '0;
        idx = int'(tid) % TABLE_DEPTH;
        case (mode)
            MODE_START:
            begin
                start_stamp[idx] = ts;
                start_armed[idx] = 1'b1;
            end
            MODE_FINISH:
            begin
                if (start_armed[idx])
                begin
                    b = latency_bucket(ts - start_stamp[idx]);
                    bucket_hits[b]   = bucket_hits[b] + 1'b1;
                    start_armed[idx] = 1'b0;
                    r.matched = 1'b1;
                    r.bucket  = BUCKET_W'(b);
                    r.count   = bucket_hits[b];
                end
            end
            MODE_READ:
            begin
                r.bucket = rb;
                if (int'(rb) < NUM_BUCKETS)
                begin
                    r.count = bucket_hits[rb];
                end
            end
            default:
            begin
                // unused mode: no state change, all-zero response
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [COUNT_W-1:0] got,
                                   input logic [COUNT_W-1:0] want);
        fail_count++;
        $display("%0t ns: mismatch on %s: got %0h, want %0h", $time, what, got, want);
    endtask

    // Track both handshakes on the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                start_armed[i] = 1'b0;
            end
            for (int i = 0; i < NUM_BUCKETS; i++) begin
                bucket_hits[i] = '0;
            end
            responses_due.delete();
            pending <= 0;
        end
        else
        begin
            // returned item against the oldest owed response
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (responses_due.size() == 0)
                begin
                    report_mismatch("item with no response due",
                                    m_axis_tdata[CNT_LSB +: COUNT_W], '0);
                end
                else
                begin
                    oldest = responses_due.pop_front();
                    if (m_axis_tuser !== oldest.matched)
                        report_mismatch("matched", COUNT_W'(m_axis_tuser),
                                        COUNT_W'(oldest.matched));
                    if (m_axis_tdata[BUCKET_W-1:0] !== oldest.bucket)
                        report_mismatch("bucket", COUNT_W'(m_axis_tdata[BUCKET_W-1:0]),
                                        COUNT_W'(oldest.bucket));
                    if (m_axis_tdata[CNT_LSB +: COUNT_W] !== oldest.count)
                        report_mismatch("count", m_axis_tdata[CNT_LSB +: COUNT_W],
                                        oldest.count);
                end
            end
            // accepted event
            if (s_axis_tvalid && s_axis_tready)
            begin
                responses_due.push_back(advance_histogram(s_axis_tuser,
                                                          s_axis_tdata[TID_W-1:0],
                                                          s_axis_tdata[TS_LSB +: TS_W],
                                                          s_axis_tdata[RB_LSB +: RB_W]));
            end
            pending <= responses_due.size();
        end
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Stimulus for the wakeup latency histogram: a directed pass over the edge
// cases, then random start/finish pairs with read and unused-mode noise,
// sent in bursts against a stalling receiver. The checker judges the items.
// ----------------------------------------------------------------------------
module tb;
    import wllh_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam int RANDOM_EVENTS = 1000;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DRAIN_CYCLES  = 12;

    logic                  clk;
    logic                  rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [MODE_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    int                    fail_count;
    int                    pending;
    int                    wd_cycles;

    // Stimulus-side memory of open starts, used only to shape latencies
    logic [TS_W-1:0] launch_stamp [int];
    int unsigned     tid_pool [16];

    wakeup_latency_log2_histogram i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    wllh_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        wd_cycles = 0;
        while (wd_cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            wd_cycles++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Receiver: runs of always ready, half ready, mostly stalled, fully stalled
    initial
    begin
        int style;
        int run_left;
        style    = 0;
        run_left = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge clk);
            if (run_left == 0)
            begin
                style    = $urandom_range(0, 3);
                run_left = (style == 3) ? $urandom_range(1, 40) : $urandom_range(8, 80);
            end
            run_left--;
            case (style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 1) == 1);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= 1'b0;
            endcase
        end
    end

    // Present one event and hold it until accepted; valid stays high after
    task automatic send_event(input logic [MODE_W-1:0] mode, input logic [TID_W-1:0] tid,
                              input logic [TS_W-1:0] ts, input logic [RB_W-1:0] rb);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[TID_W-1:0]          = tid;
        word[TS_LSB +: TS_W]     = ts;
        word[RB_LSB +: RB_W]     = rb;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= mode;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    initial
    begin
        logic [MODE_W-1:0] mode;
        logic [TID_W-1:0]  tid;
        logic [TS_W-1:0]   ts;
        logic [TS_W-1:0]   delta;
        int                pick;
        int                sent;
        int                burst;
        int                gap;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = MODE_START;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty histogram, unmatched finish, bucket edges, wraparound
        send_event(MODE_READ,   12'd0,    '0,                      6'd0);
        send_event(MODE_READ,   12'd0,    '1,                      6'd63);
        send_event(MODE_FINISH, 12'd5,    64'd1000,                6'd0);
        send_event(MODE_START,  12'd0,    64'd0,                   6'd0);
        send_event(MODE_FINISH, 12'd0,    64'd0,                   6'd0);
        send_event(MODE_START,  12'd4095, 64'd100,                 6'd63);
        send_event(MODE_FINISH, 12'd4095, 64'd101,                 6'd63);
        send_event(MODE_START,  12'd1,    64'd10,                  6'd0);
        send_event(MODE_FINISH, 12'd1,    64'd12,                  6'd0);
        // finish time below start time: difference wraps to 2^63
        send_event(MODE_START,  12'd2,    64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        send_event(MODE_FINISH, 12'd2,    64'h7FFF_FFFF_FFFF_FFFF, 6'd0);
        send_event(MODE_START,  12'd3,    64'd0,                   6'd0);
        send_event(MODE_FINISH, 12'd3,    64'hFFFF_FFFF_FFFF_FFFF, 6'd0);
        // second start replaces the first; repeat finish finds nothing
        send_event(MODE_START,  12'd7,    64'd50,                  6'd0);
        send_event(MODE_START,  12'd7,    64'd60,                  6'd0);
        send_event(MODE_FINISH, 12'd7,    64'd64,                  6'd0);
        send_event(MODE_FINISH, 12'd7,    64'd80,                  6'd0);
        send_event(MODE_UNUSED, 12'hFFF,  '1,                      6'h3F);
        send_event(MODE_READ,   12'hFFF,  '1,                      6'd0);
        send_event(MODE_READ,   12'd0,    '0,                      6'd1);
        send_event(MODE_READ,   12'd0,    '0,                      6'd2);
        send_event(MODE_READ,   12'd0,    '0,                      6'd63);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        // Thread ids reused often enough that most finishes match
        tid_pool[0] = 0;
        tid_pool[1] = TABLE_DEPTH - 1;
        for (int i = 2; i < 16; i++) begin
            tid_pool[i] = $urandom_range(0, TABLE_DEPTH - 1);
        end

        // Random bursts
        sent = 0;
        while (sent < RANDOM_EVENTS) begin
            burst = $urandom_range(1, 12);
            for (int k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                tid  = ($urandom_range(0, 9) == 0) ? TID_W'($urandom_range(0, 4095))
                                                   : TID_W'(tid_pool[$urandom_range(0, 15)]);
                ts   = {$urandom, $urandom};
                if (pick < 40)
                begin
                    mode = MODE_START;
                    launch_stamp[int'(tid)] = ts;
                end
                else if (pick < 80)
                begin
                    // latency of random bit length, so every bucket shows up
                    mode  = MODE_FINISH;
                    delta = {$urandom, $urandom} >> $urandom_range(0, 64);
                    if (launch_stamp.exists(int'(tid)))
                    begin
                        ts = launch_stamp[int'(tid)] + delta;
                        launch_stamp.delete(int'(tid));
                    end
                end
                else if (pick < 95)
                begin
                    mode = MODE_READ;
                end
                else
                begin
                    mode = MODE_UNUSED;
                end
                send_event(mode, tid, ts, RB_W'($urandom_range(0, 63)));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then allow for the longest event latency
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/wllh_pkg.sv
rtl/wllh_ram.sv
rtl/wakeup_latency_log2_histogram.sv
rtl/wllh_checker.sv
tb/wllh_checker.sv
tb/tb.sv
